// ===== sv/r2fft_pkg.sv =====
// Package for the radix-2 FFT engine: word types, register indexes, the
// quarter-wave cosine table and elaboration-time helpers. No dependencies.
package r2fft_pkg;

  localparam int MAX_POINTS_DEF   = 64;
  localparam int TWIDDLE_BITS_DEF = 16;
  localparam int DATA_W           = 24;
  localparam int TABLE_FRAC       = 22;
  localparam int CFG_W            = 3;
  localparam int CFG_IDX_W        = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] result_re;
    logic signed [23:0] result_im;
    logic [5:0]         bin_index;
    logic               last_result;
  } out_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } cplx_t;

  // cos(2*pi*i/64) in Q1.22, i = 0 .. 16
  localparam int QUARTER_COS [17] = '{
    4194304, 4174107, 4113712, 4013699, 3875032, 3699046, 3487436, 3242241,
    2965821, 2660838, 2330230, 1977181, 1605091, 1217542, 818268, 411114, 0
  };

  // Largest log2 length, at most six, whose length fits in mp points.
  function automatic int max_log(input int mp);
    int l;
    l = 1;
    for (int i = 0; i < 5; i++) begin
      if (l < 6 && (1 << (l + 1)) <= mp) l = l + 1;
    end
    return l;
  endfunction

  // Twiddle magnitude from the table, rounded half up to tb-2 fraction bits.
  function automatic logic signed [23:0] tw_mag(input logic [4:0] i, input int tb);
    int sh;
    int q;
    sh = TABLE_FRAC - (tb - 2);
    q  = (i > 5'd16) ? QUARTER_COS[16] : QUARTER_COS[i];
    if (sh == 0) return 24'(q);
    return 24'((q + (1 << (sh - 1))) >>> sh);
  endfunction

endpackage

// ===== sv/radix2_fft_engine.sv =====
// Radix-2 FFT/IFFT engine: loads 2^L samples, one per start, then runs the
// butterflies through one shared unit, each in the steps read, multiply,
// write upper leg and write lower leg. Once the last butterfly is written,
// the result words are strobed one per cycle; the receiver cannot stall.
// busy is high from the last sample until the final word has been registered.
// Synchronous active-low reset: length 64, forward.
module radix2_fft_engine
  import r2fft_pkg::*;
#(
  parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_DEF,
  parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  r2fft_pkg::in_word_t               in_word,
  output logic                              out_strobe,
  output r2fft_pkg::out_word_t              out_word,
  input  logic                              cfg_we,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [r2fft_pkg::CFG_W-1:0]       cfg_data
);

  localparam int MAX_LOG = max_log(MAX_POINTS);
  localparam int AW      = MAX_LOG;
  localparam int DEPTH   = 1 << AW;
  localparam int TWB     = TWIDDLE_BITS;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_WRQ  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  cplx_t mem [DEPTH];

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    log2_r;
  logic          inv_r;
  logic [AW-1:0] cnt_r;
  logic [2:0]    stage_r;
  logic [AW-1:0] bfly_r;
  cplx_t         rd_p_r, rd_q_r, q_res_r;
  logic          emit_r, elast_r, out_strobe_r;
  logic [AW-1:0] eidx_r;
  out_word_t     out_word_r;

  logic [2:0]    l_act;
  logic [AW-1:0] len_mask, bf_mask, half, half_mask, k, p_addr, q_addr;
  logic [AW-1:0] rev, load_addr, rd_addr_p, rd_addr_q;
  logic [AW+4:0] kx;
  logic [4:0]    m;
  logic signed [23:0] mag_a, mag_b;
  logic signed [TWB-1:0] wc, ws;
  logic          accept, rd_en, we;
  logic [AW-1:0] waddr;
  cplx_t         wdata, bf_sum, bf_dif;
  logic signed [24:0] sc_re, sc_im;

  always_comb begin
    if (log2_r == 3'd0) l_act = 3'd1;
    else if (log2_r > 3'(MAX_LOG)) l_act = 3'(MAX_LOG);
    else l_act = log2_r;
  end

  assign len_mask  = AW'(((AW + 1)'(1) << l_act) - (AW + 1)'(1));
  assign bf_mask   = len_mask >> 1;
  assign half      = AW'((AW + 1)'(1) << stage_r);
  assign half_mask = AW'(((AW + 1)'(1) << stage_r) - (AW + 1)'(1));
  assign k         = bfly_r & half_mask;
  // Upper leg: a zero bit inserted into the butterfly count at the span bit.
  assign p_addr    = AW'({bfly_r & ~half_mask, 1'b0}) | k;
  assign q_addr    = p_addr | half;
  assign kx        = (AW + 5)'(k) << (3'd5 - stage_r);
  assign m         = kx[4:0];

  always_comb begin
    for (int i = 0; i < AW; i++) rev[i] = cnt_r[AW-1-i];
  end
  assign load_addr = rev >> (3'(AW) - l_act);

  // Twiddle for angle 2*pi*m/64; inverse mode conjugates it.
  always_comb begin
    if (m <= 5'd16) begin
      mag_a = tw_mag(m, TWB);
      mag_b = tw_mag(5'd16 - m, TWB);
      wc = mag_a[TWB-1:0];
      ws = mag_b[TWB-1:0];
    end else begin
      mag_a = tw_mag(5'(6'd32 - {1'b0, m}), TWB);
      mag_b = tw_mag(m - 5'd16, TWB);
      wc = -mag_a[TWB-1:0];
      ws = mag_b[TWB-1:0];
    end
    if (inv_r) ws = -ws;
  end

  r2fft_bfly #(.TWB(TWB)) u_bfly (
    .clk    (clk),
    .mul_en (state_r == S_MUL),
    .u      (rd_p_r),
    .v      (rd_q_r),
    .wc     (wc),
    .ws     (ws),
    .sum    (bf_sum),
    .dif    (bf_dif)
  );

  assign accept = start && !busy;
  assign busy   = (state_r != S_LOAD) || emit_r;

  always_comb begin
    we    = 1'b0;
    waddr = p_addr;
    wdata = bf_sum;
    unique case (state_r)
      S_LOAD: begin
        we       = accept;
        waddr    = load_addr;
        wdata.re = DATA_W'(in_word.sample_re);
        wdata.im = DATA_W'(in_word.sample_im);
      end
      S_SUM: we = 1'b1;
      S_WRQ: begin
        we    = 1'b1;
        waddr = q_addr;
        wdata = q_res_r;
      end
      default: we = 1'b0;
    endcase
  end

  assign rd_en     = (state_r == S_RD) || (state_r == S_OUT);
  assign rd_addr_p = (state_r == S_OUT) ? cnt_r : p_addr;
  assign rd_addr_q = q_addr;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) begin
      rd_p_r <= mem[rd_addr_p];
      rd_q_r <= mem[rd_addr_q];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:  if (accept && cnt_r == len_mask && !(cfg_we && cfg_index == CFG_LOG2_LENGTH))
                 state_nxt = S_RD;
      S_RD:    state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_WRQ;
      S_WRQ:   state_nxt = (bfly_r == bf_mask && stage_r == l_act - 3'd1) ? S_OUT : S_RD;
      S_OUT:   if (cnt_r == len_mask) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      log2_r       <= 3'd6;
      inv_r        <= 1'b0;
      cnt_r        <= '0;
      stage_r      <= 3'd0;
      bfly_r       <= '0;
      emit_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      emit_r       <= (state_r == S_OUT);
      out_strobe_r <= emit_r;
      if (state_r == S_LOAD && accept) begin
        stage_r <= 3'd0;
        bfly_r  <= '0;
      end
      if (state_r == S_WRQ) begin
        if (bfly_r == bf_mask) begin
          bfly_r  <= '0;
          stage_r <= stage_r + 3'd1;
        end else begin
          bfly_r <= bfly_r + 1'b1;
        end
      end
      // A length write drops any partial load.
      if (cfg_we && cfg_index == CFG_LOG2_LENGTH) begin
        cnt_r <= '0;
      end else if ((state_r == S_LOAD && accept) || state_r == S_OUT) begin
        cnt_r <= (cnt_r == len_mask) ? '0 : cnt_r + 1'b1;
      end
      if (cfg_we && cfg_index == CFG_LOG2_LENGTH) log2_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_INVERSE_MODE) inv_r <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SUM) q_res_r <= bf_dif;
    eidx_r  <= cnt_r;
    elast_r <= (cnt_r == len_mask);
  end

  // Inverse scaling: add half an LSB of the length and shift down by L.
  assign sc_re = ($signed({rd_p_r.re[23], rd_p_r.re}) + (25'sd1 <<< (l_act - 3'd1))) >>> l_act;
  assign sc_im = ($signed({rd_p_r.im[23], rd_p_r.im}) + (25'sd1 <<< (l_act - 3'd1))) >>> l_act;

  always_ff @(posedge clk) begin
    if (emit_r) begin
      out_word_r.result_re   <= inv_r ? sc_re[23:0] : rd_p_r.re;
      out_word_r.result_im   <= inv_r ? sc_im[23:0] : rd_p_r.im;
      out_word_r.bin_index   <= 6'(eidx_r);
      out_word_r.last_result <= elast_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// ===== sv/r2fft_bfly.sv =====
// Butterfly unit of the radix-2 FFT engine: registered complex product of the
// lower leg with the twiddle, then rounding, sum, difference and saturation.
// Depends on r2fft_pkg.
module r2fft_bfly #(
  parameter int TWB = r2fft_pkg::TWIDDLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  mul_en,
  input  r2fft_pkg::cplx_t      u,
  input  r2fft_pkg::cplx_t      v,
  input  logic signed [TWB-1:0] wc,
  input  logic signed [TWB-1:0] ws,
  output r2fft_pkg::cplx_t      sum,
  output r2fft_pkg::cplx_t      dif
);
  import r2fft_pkg::*;

  localparam int PR = DATA_W + TWB;
  localparam int F  = TWB - 2;
  localparam logic signed [PR:0] RND = (PR + 1)'(1) << (F - 1);

  logic signed [PR-1:0] prr_r, pii_r, pri_r, pir_r;
  logic signed [PR:0]   tr_full, ti_full, tr, ti;
  logic signed [PR+1:0] s_re, s_im, d_re, d_im;

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [PR+1:0] x);
    logic hi_same;
    hi_same = (&x[PR+1:DATA_W-1]) || !(|x[PR+1:DATA_W-1]);
    if (hi_same) return x[DATA_W-1:0];
    return x[PR+1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prr_r <= v.re * wc;
      pii_r <= v.im * ws;
      pri_r <= v.re * ws;
      pir_r <= v.im * wc;
    end
  end

  assign tr_full = prr_r - pii_r + RND;
  assign ti_full = pri_r + pir_r + RND;
  assign tr = tr_full >>> F;
  assign ti = ti_full >>> F;

  assign s_re = u.re + tr;
  assign s_im = u.im + ti;
  assign d_re = u.re - tr;
  assign d_im = u.im - ti;

  assign sum.re = sat(s_re);
  assign sum.im = sat(s_im);
  assign dif.re = sat(d_re);
  assign dif.im = sat(d_im);

endmodule
